FILE: src/steering_speed_differential_controller_macros.svh
// Assertion shorthands for the steering and differential controller.
`ifndef STEERING_SPEED_DIFFERENTIAL_CONTROLLER_MACROS_SVH
`define STEERING_SPEED_DIFFERENTIAL_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDC_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles.
`define SDC_ASSERT_DELAY(lbl, ant, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> ##dly (cons)) \
		else $error(msg);

`endif

FILE: src/sdc_pkg.sv
package sdc_pkg;

	localparam int TAN_TABLE_ENTRIES_DEF = 1024;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] CFG_STEER_LIMIT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_STEP  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_WHEEL_CIRC  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_WHEEL_BASE  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_TRACK_WIDTH = 3'd4;

	localparam logic [12:0] RST_STEER_LIMIT = 13'd1920;
	localparam logic [15:0] RST_ACCEL_STEP  = 16'd256;
	localparam logic [15:0] RST_WHEEL_CIRC  = 16'd256;
	localparam logic [15:0] RST_WHEEL_BASE  = 16'd1024;
	localparam logic [15:0] RST_TRACK_WIDTH = 16'd512;

	localparam logic [12:0] MAX_STEER = 13'd5120;

	// index = (|steer| * N + 2880) / 5760, with 5760 = 45 << 7
	localparam int IDX_ROUND       = 2880;
	localparam int IDX_PRE_SHIFT   = 7;
	localparam int IDX_ODD         = 45;
	localparam int IDX_RECIP_SHIFT = 24;
	localparam int RECIP_W         = 19;
	localparam longint unsigned IDX_RECIP = (64'd1 << IDX_RECIP_SHIFT) / IDX_ODD;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	localparam logic [45:0] RADIUS_CAP = 46'h3FFF_FFFF_FFFF;
	localparam logic [39:0] QUOT_CAP   = 40'h80_0000_0000;
	localparam logic [15:0] RATIO_ONE  = 16'd4096;
	localparam logic [15:0] SAT16      = 16'hFFFF;

	// p / (k * (k + 1)) for the Taylor terms
	function automatic logic [63:0] div_kk(input logic [63:0] p, input int k);
		case (k)
			1:  return p / 64'd2;
			2:  return p / 64'd6;
			3:  return p / 64'd12;
			4:  return p / 64'd20;
			5:  return p / 64'd30;
			6:  return p / 64'd42;
			7:  return p / 64'd56;
			8:  return p / 64'd72;
			9:  return p / 64'd90;
			10: return p / 64'd110;
			11: return p / 64'd132;
			12: return p / 64'd156;
			13: return p / 64'd182;
			14: return p / 64'd210;
			15: return p / 64'd240;
			16: return p / 64'd272;
			17: return p / 64'd306;
			18: return p / 64'd342;
			19: return p / 64'd380;
			20: return p / 64'd420;
			default: return 64'd0;
		endcase
	endfunction

	// eleven-term alternating series, Q30; k0 = 2 for sine, 1 for cosine
	function automatic logic [63:0] taylor(input logic [63:0] t0, input logic [63:0] x2,
			input int k0);
		logic [63:0] t;
		logic [63:0] pos;
		logic [63:0] neg;
		int k;
		t = t0;
		pos = t0;
		neg = 64'd0;
		k = k0;
		for (int n = 1; n <= 10; n++) begin
			t = div_kk((t * x2) >> 30, k);
			k = k + 2;
			if (n[0]) begin
				neg = neg + t;
			end else begin
				pos = pos + t;
			end
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

endpackage

FILE: src/sdc_div.sv
// Restoring divider, one quotient bit per stage. Caller guarantees num >> Q_W < den.
module sdc_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 16,
	parameter int Q_W   = 24,
	parameter int PAY_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [PAY_W-1:0] in_pay,
	output logic             out_valid,
	output logic [Q_W-1:0]   out_quot,
	output logic [PAY_W-1:0] out_pay
);

	logic             vld_s [Q_W];
	logic [NUM_W-1:0] num_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [DEN_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];
	logic [PAY_W-1:0] pay_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic             vld_i;
		logic [NUM_W-1:0] num_i;
		logic [DEN_W-1:0] den_i;
		logic [DEN_W-1:0] rem_i;
		logic [Q_W-1:0]   quo_i;
		logic [PAY_W-1:0] pay_i;
		logic [DEN_W:0]   trial;
		logic             take;

		if (k == 0) begin : g_first
			assign vld_i = in_valid;
			assign num_i = in_num;
			assign den_i = in_den;
			assign rem_i = DEN_W'(in_num >> Q_W);
			assign quo_i = '0;
			assign pay_i = in_pay;
		end else begin : g_next
			assign vld_i = vld_s[k-1];
			assign num_i = num_s[k-1];
			assign den_i = den_s[k-1];
			assign rem_i = rem_s[k-1];
			assign quo_i = quo_s[k-1];
			assign pay_i = pay_s[k-1];
		end

		assign trial = {rem_i, num_i[Q_W-1-k]};
		assign take  = trial >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			num_s[k] <= num_i;
			den_s[k] <= den_i;
			rem_s[k] <= take ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
			quo_s[k] <= {quo_i[Q_W-2:0], take};
			pay_s[k] <= pay_i;
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign out_quot  = quo_s[Q_W-1];
	assign out_pay   = pay_s[Q_W-1];

endmodule

FILE: src/steering_speed_differential_controller.sv
// Steering clamp, speed ramp and rear electronic differential, fully pipelined.
// Throughput: one transfer per clock; busy is always low and results cannot be held off.
// Stage count is set by the dividers: 24 (rear rate), 46 (radius), 40 (wheel quotients).
// Reset (arst_n low) clears every stage valid and loads the register defaults at once.
`include "steering_speed_differential_controller_macros.svh"

module steering_speed_differential_controller #(
	parameter int TAN_TABLE_ENTRIES = sdc_pkg::TAN_TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            cfg_we,
	input  logic [sdc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [sdc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic signed [14:0]              heading_now,
	input  logic signed [14:0]              heading_goal,
	input  logic [15:0]                     speed_now,
	input  logic [15:0]                     speed_goal,
	output logic                            done,
	output logic signed [13:0]              steer_angle,
	output logic [15:0]                     speed_next,
	output logic [15:0]                     left_wheel_rate,
	output logic [15:0]                     right_wheel_rate,
	output logic [15:0]                     turn_radius,
	output logic [15:0]                     wheel_ratio
);

	// widths that follow from the table size
	localparam int IDX_W   = $clog2(TAN_TABLE_ENTRIES);
	localparam int IDXN_W  = 14 + IDX_W;               // |steer| * N + round
	localparam int V_W     = IDXN_W - sdc_pkg::IDX_PRE_SHIFT;
	localparam int PROD_W  = V_W + sdc_pkg::RECIP_W;

	localparam int REAR_Q_W = 24;
	localparam int RAD_Q_W  = 46;
	localparam int QUO_Q_W  = 40;
	localparam int LATENCY  = 1 + REAR_Q_W + 4 + RAD_Q_W + 1 + QUO_Q_W + 2;

	typedef struct packed {
		logic signed [13:0] steer;
		logic [15:0]        spd;
	} rear_pay_t;

	typedef struct packed {
		logic signed [13:0] steer;
		logic [15:0]        spd;
		logic [23:0]        rear;
	} base_t;

	typedef struct packed {
		base_t b;
		logic  straight;
		logic  rsat;
	} rad_pay_t;

	typedef struct packed {
		base_t       b;
		logic        straight;
		logic [15:0] radius;
		logic        ovf;
		logic        lr_zero;
		logic        rr_zero;
	} quo_pay_t;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [12:0] steering_limit_q;
	logic [15:0] accel_step_q;
	logic [15:0] wheel_circ_q;
	logic [15:0] wheel_base_q;
	logic [15:0] track_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steering_limit_q <= sdc_pkg::RST_STEER_LIMIT;
			accel_step_q     <= sdc_pkg::RST_ACCEL_STEP;
			wheel_circ_q     <= sdc_pkg::RST_WHEEL_CIRC;
			wheel_base_q     <= sdc_pkg::RST_WHEEL_BASE;
			track_width_q    <= sdc_pkg::RST_TRACK_WIDTH;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				sdc_pkg::CFG_STEER_LIMIT: steering_limit_q <= cfg_data[12:0];
				sdc_pkg::CFG_ACCEL_STEP:  accel_step_q     <= cfg_data;
				sdc_pkg::CFG_WHEEL_CIRC:  wheel_circ_q     <= cfg_data;
				sdc_pkg::CFG_WHEEL_BASE:  wheel_base_q     <= cfg_data;
				sdc_pkg::CFG_TRACK_WIDTH: track_width_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Every cycle takes a transfer.
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// Tangent table, Q16.16, built at elaboration; read with a registered port
	// ---------------------------------------------------------------
	logic [31:0] tan_rom [TAN_TABLE_ENTRIES];

	for (genvar gi = 0; gi < TAN_TABLE_ENTRIES; gi++) begin : g_tan
		localparam logic [63:0] X  = (64'(gi) * sdc_pkg::PI_Q30) /
			(64'd2 * 64'(TAN_TABLE_ENTRIES));
		localparam logic [63:0] X2 = (X * X) >> 30;
		localparam logic [63:0] SN = sdc_pkg::taylor(X, X2, 2);
		localparam logic [63:0] CS = sdc_pkg::taylor(sdc_pkg::ONE_Q30, X2, 1);
		localparam logic [63:0] QT = (CS == 64'd0) ? 64'hFFFF_FFFF :
			(SN << 16) / ((CS == 64'd0) ? 64'd1 : CS);
		assign tan_rom[gi] = (QT > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : QT[31:0];
	end

	// ---------------------------------------------------------------
	// Stage 1: heading error clamp and speed ramp
	// ---------------------------------------------------------------
	logic signed [15:0] delta;
	logic [15:0]        mag;
	logic [12:0]        lim;
	logic signed [13:0] steer_c;
	logic [16:0]        spd_up;
	logic [15:0]        spd_dn_gap;
	logic [15:0]        spd_c;

	assign delta = $signed({heading_goal[14], heading_goal}) -
		$signed({heading_now[14], heading_now});
	assign mag = delta[15] ? 16'(-delta) : 16'(delta);
	assign lim = (steering_limit_q > sdc_pkg::MAX_STEER) ? sdc_pkg::MAX_STEER : steering_limit_q;

	always_comb begin
		if (delta == 16'sd0) begin
			steer_c = 14'sd0;
		end else if (mag >= {3'b000, lim}) begin
			steer_c = delta[15] ? 14'(-$signed({1'b0, lim})) : $signed({1'b0, lim});
		end else begin
			steer_c = 14'(delta);
		end
	end

	// ramp toward the goal, never past it
	assign spd_up     = {1'b0, speed_now} + {1'b0, accel_step_q};
	assign spd_dn_gap = speed_now - speed_goal;

	always_comb begin
		if (speed_goal > speed_now) begin
			spd_c = (spd_up > {1'b0, speed_goal}) ? speed_goal : spd_up[15:0];
		end else begin
			spd_c = (accel_step_q > spd_dn_gap) ? speed_goal : speed_now - accel_step_q;
		end
	end

	logic               v_s1;
	logic signed [13:0] steer_s1;
	logic [15:0]        spd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		steer_s1 <= steer_c;
		spd_s1   <= spd_c;
	end

	// ---------------------------------------------------------------
	// Rear wheel rate: speed * 256 / circumference (zero acts as one)
	// ---------------------------------------------------------------
	rear_pay_t   rear_pay_in;
	rear_pay_t   rear_pay_out;
	logic        rear_vld;
	logic [23:0] rear_quo;
	logic [15:0] circ;

	assign circ = (wheel_circ_q == 16'd0) ? 16'd1 : wheel_circ_q;
	assign rear_pay_in.steer = steer_s1;
	assign rear_pay_in.spd   = spd_s1;

	sdc_div #(
		.NUM_W (24),
		.DEN_W (16),
		.Q_W   (REAR_Q_W),
		.PAY_W ($bits(rear_pay_t))
	) u_rear_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_num    ({spd_s1, 8'h00}),
		.in_den    (circ),
		.in_pay    (rear_pay_in),
		.out_valid (rear_vld),
		.out_quot  (rear_quo),
		.out_pay   (rear_pay_out)
	);

	// ---------------------------------------------------------------
	// Stages 2-4: table index = (|steer| * N + 2880) / 5760
	// by shift of 7 and a reciprocal multiply for 45, one correction step
	// ---------------------------------------------------------------
	logic [12:0]       steer_abs;
	logic              v_s2;
	base_t             base_s2;
	logic [IDXN_W-1:0] idxn_s2;

	assign steer_abs = rear_pay_out.steer[13] ? 13'(-rear_pay_out.steer) :
		13'(rear_pay_out.steer);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= rear_vld;
		end
	end

	always_ff @(posedge clk) begin
		base_s2.steer <= rear_pay_out.steer;
		base_s2.spd   <= rear_pay_out.spd;
		base_s2.rear  <= rear_quo;
		idxn_s2       <= IDXN_W'(steer_abs) * IDXN_W'(TAN_TABLE_ENTRIES) +
			IDXN_W'(sdc_pkg::IDX_ROUND);
	end

	logic [V_W-1:0]    idxv;
	logic              v_s3;
	base_t             base_s3;
	logic [V_W-1:0]    idxv_s3;
	logic [PROD_W-1:0] prod_s3;

	assign idxv = V_W'(idxn_s2 >> sdc_pkg::IDX_PRE_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		base_s3 <= base_s2;
		idxv_s3 <= idxv;
		prod_s3 <= PROD_W'(idxv) * PROD_W'(sdc_pkg::IDX_RECIP);
	end

	// estimate is exact or one low
	logic [V_W-1:0]   q_est;
	logic [V_W-1:0]   q_rem;
	logic [V_W-1:0]   q_fix;
	logic             v_s4;
	base_t            base_s4;
	logic [IDX_W-1:0] idx_s4;

	assign q_est = V_W'(prod_s3 >> sdc_pkg::IDX_RECIP_SHIFT);
	assign q_rem = idxv_s3 - V_W'(q_est * V_W'(sdc_pkg::IDX_ODD));
	assign q_fix = (q_rem >= V_W'(sdc_pkg::IDX_ODD)) ? q_est + V_W'(1) : q_est;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		base_s4 <= base_s3;
		idx_s4  <= (q_fix > V_W'(TAN_TABLE_ENTRIES - 1)) ? IDX_W'(TAN_TABLE_ENTRIES - 1) :
			q_fix[IDX_W-1:0];
	end

	// ---------------------------------------------------------------
	// Stage 5: table read
	// ---------------------------------------------------------------
	logic        v_s5;
	base_t       base_s5;
	logic [31:0] tan_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		base_s5 <= base_s4;
		tan_s5  <= tan_rom[idx_s4];
	end

	// ---------------------------------------------------------------
	// Turning radius R = wheel_base * 2^32 / tan, Q16.16, capped below 2^46
	// ---------------------------------------------------------------
	rad_pay_t             rad_pay_in;
	rad_pay_t             rad_pay_out;
	logic                 rad_vld;
	logic [RAD_Q_W-1:0]   rad_quo;

	assign rad_pay_in.b        = base_s5;
	assign rad_pay_in.straight = (base_s5.steer == 14'sd0) || (tan_s5 == 32'd0);
	// quotient reaches 2^46 exactly when wheel_base >> 14 is not below tan
	assign rad_pay_in.rsat     = {30'd0, wheel_base_q[15:14]} >= tan_s5;

	sdc_div #(
		.NUM_W (48),
		.DEN_W (32),
		.Q_W   (RAD_Q_W),
		.PAY_W ($bits(rad_pay_t))
	) u_rad_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_num    ({wheel_base_q, 32'd0}),
		.in_den    (tan_s5),
		.in_pay    (rad_pay_in),
		.out_valid (rad_vld),
		.out_quot  (rad_quo),
		.out_pay   (rad_pay_out)
	);

	// ---------------------------------------------------------------
	// Stage 6: inner and outer radius, left/right assignment
	// ---------------------------------------------------------------
	logic [45:0] rad_r;
	logic [30:0] half_track;
	logic [46:0] r_inner;
	logic [46:0] r_outer;

	assign rad_r      = rad_pay_out.rsat ? sdc_pkg::RADIUS_CAP : rad_quo;
	assign half_track = {track_width_q, 15'd0};
	assign r_inner    = (rad_r > 46'(half_track)) ? {1'b0, rad_r - 46'(half_track)} : 47'd0;
	assign r_outer    = {1'b0, rad_r} + 47'(half_track);

	logic        v_s6;
	base_t       base_s6;
	logic        straight_s6;
	logic [15:0] radius_s6;
	logic [46:0] lr_s6;
	logic [46:0] rr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= rad_vld;
		end
	end

	// steer > 0 turns left: left wheel runs on the inner radius
	always_ff @(posedge clk) begin
		base_s6     <= rad_pay_out.b;
		straight_s6 <= rad_pay_out.straight;
		radius_s6   <= (|rad_r[45:32]) ? sdc_pkg::SAT16 : rad_r[31:16];
		if (!rad_pay_out.b.steer[13]) begin
			lr_s6 <= r_inner;
			rr_s6 <= r_outer;
		end else begin
			lr_s6 <= r_outer;
			rr_s6 <= r_inner;
		end
	end

	// ---------------------------------------------------------------
	// Wheel quotients own * 2^16 / other, 40 bits; anything above 2^39 caps
	// ---------------------------------------------------------------
	quo_pay_t           ql_pay_in;
	quo_pay_t           ql_pay_out;
	logic               ql_vld;
	logic [QUO_Q_W-1:0] ql_quo;
	logic               qr_ovf_in;
	logic               qr_ovf_out;
	logic               qr_vld;
	logic [QUO_Q_W-1:0] qr_quo;

	assign ql_pay_in.b        = base_s6;
	assign ql_pay_in.straight = straight_s6;
	assign ql_pay_in.radius   = radius_s6;
	assign ql_pay_in.ovf      = (lr_s6 >> 24) >= rr_s6;
	assign ql_pay_in.lr_zero  = lr_s6 == 47'd0;
	assign ql_pay_in.rr_zero  = rr_s6 == 47'd0;
	assign qr_ovf_in          = (rr_s6 >> 24) >= lr_s6;

	sdc_div #(
		.NUM_W (63),
		.DEN_W (47),
		.Q_W   (QUO_Q_W),
		.PAY_W ($bits(quo_pay_t))
	) u_ql_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_num    ({lr_s6, 16'd0}),
		.in_den    (rr_s6),
		.in_pay    (ql_pay_in),
		.out_valid (ql_vld),
		.out_quot  (ql_quo),
		.out_pay   (ql_pay_out)
	);

	sdc_div #(
		.NUM_W (63),
		.DEN_W (47),
		.Q_W   (QUO_Q_W),
		.PAY_W (1)
	) u_qr_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_num    ({rr_s6, 16'd0}),
		.in_den    (lr_s6),
		.in_pay    (qr_ovf_in),
		.out_valid (qr_vld),
		.out_quot  (qr_quo),
		.out_pay   (qr_ovf_out)
	);

	// ---------------------------------------------------------------
	// Stage 7: cap quotients, ratio, split products rear * q
	// ---------------------------------------------------------------
	logic [39:0] ql_cap;
	logic [39:0] qr_cap;

	assign ql_cap = (ql_pay_out.ovf || ql_quo > sdc_pkg::QUOT_CAP) ? sdc_pkg::QUOT_CAP : ql_quo;
	assign qr_cap = (qr_ovf_out || qr_quo > sdc_pkg::QUOT_CAP) ? sdc_pkg::QUOT_CAP : qr_quo;

	logic        v_s7;
	quo_pay_t    pay_s7;
	logic [15:0] ratio_s7;
	logic [43:0] pl_lo_s7;
	logic [43:0] pl_hi_s7;
	logic [43:0] pr_lo_s7;
	logic [43:0] pr_hi_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= ql_vld;
		end
	end

	// ratio = floor(q_left / 16) since floor of a floor is exact
	always_ff @(posedge clk) begin
		pay_s7 <= ql_pay_out;
		if (ql_pay_out.rr_zero) begin
			ratio_s7 <= ql_pay_out.lr_zero ? 16'd0 : sdc_pkg::SAT16;
		end else begin
			ratio_s7 <= (|ql_cap[39:20]) ? sdc_pkg::SAT16 : ql_cap[19:4];
		end
		pl_lo_s7 <= 44'(ql_pay_out.b.rear) * 44'(ql_cap[19:0]);
		pl_hi_s7 <= 44'(ql_pay_out.b.rear) * 44'(ql_cap[39:20]);
		pr_lo_s7 <= 44'(ql_pay_out.b.rear) * 44'(qr_cap[19:0]);
		pr_hi_s7 <= 44'(ql_pay_out.b.rear) * 44'(qr_cap[39:20]);
	end

	// ---------------------------------------------------------------
	// Stage 8: sum partial products, saturate, pick the straight-line case
	// ---------------------------------------------------------------
	logic [63:0] sum_l;
	logic [63:0] sum_r;
	logic [15:0] rate_l;
	logic [15:0] rate_r;
	logic [15:0] rear_sat;
	logic        rear_zero;

	assign sum_l     = (64'(pl_hi_s7) << 20) + 64'(pl_lo_s7);
	assign sum_r     = (64'(pr_hi_s7) << 20) + 64'(pr_lo_s7);
	assign rear_sat  = (|pay_s7.b.rear[23:16]) ? sdc_pkg::SAT16 : pay_s7.b.rear[15:0];
	assign rear_zero = pay_s7.b.rear == 24'd0;

	// zero divisor radius: full scale unless nothing to scale
	always_comb begin
		if (pay_s7.rr_zero) begin
			rate_l = (rear_zero || pay_s7.lr_zero) ? 16'd0 : sdc_pkg::SAT16;
		end else begin
			rate_l = (|sum_l[63:32]) ? sdc_pkg::SAT16 : sum_l[31:16];
		end
		if (pay_s7.lr_zero) begin
			rate_r = (rear_zero || pay_s7.rr_zero) ? 16'd0 : sdc_pkg::SAT16;
		end else begin
			rate_r = (|sum_r[63:32]) ? sdc_pkg::SAT16 : sum_r[31:16];
		end
	end

	logic               v_s8;
	logic signed [13:0] steer_s8;
	logic [15:0]        spd_s8;
	logic [15:0]        left_s8;
	logic [15:0]        right_s8;
	logic [15:0]        radius_s8;
	logic [15:0]        ratio_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		steer_s8 <= pay_s7.b.steer;
		spd_s8   <= pay_s7.b.spd;
		if (pay_s7.straight) begin
			left_s8   <= rear_sat;
			right_s8  <= rear_sat;
			radius_s8 <= sdc_pkg::SAT16;
			ratio_s8  <= sdc_pkg::RATIO_ONE;
		end else begin
			left_s8   <= rate_l;
			right_s8  <= rate_r;
			radius_s8 <= pay_s7.radius;
			ratio_s8  <= ratio_s7;
		end
	end

	assign done             = v_s8;
	assign steer_angle      = steer_s8;
	assign speed_next       = spd_s8;
	assign left_wheel_rate  = left_s8;
	assign right_wheel_rate = right_s8;
	assign turn_radius      = radius_s8;
	assign wheel_ratio      = ratio_s8;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`SDC_ASSERT_DELAY(a_fixed_latency, start && !busy, LATENCY, done, "result strobe missing")
	`SDC_ASSERT_NOW(a_quot_align, ql_vld, qr_vld, "wheel quotient dividers out of step")
	`SDC_ASSERT_NOW(a_straight, done && steer_angle == 14'sd0, turn_radius == sdc_pkg::SAT16 && wheel_ratio == sdc_pkg::RATIO_ONE && left_wheel_rate == right_wheel_rate, "straight result wrong")
	`SDC_ASSERT_NOW(a_left_turn, done && steer_angle > 14'sd0, left_wheel_rate <= right_wheel_rate, "inner wheel faster on left turn")

endmodule
